// File: rtl/assert_macros.svh
// assertion macros used by the port checker in rtl/wsd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define WSD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// property checked on every clock edge, reset included
`define WSD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/wsd_pkg.sv
// shared types and constants for the work stealing deque
package wsd_pkg;

    localparam int CAPACITY     = 16;
    localparam int HANDLE_WIDTH = 32;
    localparam int WORK_W       = 32;
    localparam int OCC_W        = 5;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int M_TDATA_W    = 40;
    localparam int PAD_W        = M_TDATA_W - WORK_W - OCC_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_STEAL = 2'd2,
        CMD_BATCH = 2'd3
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK    = 2'd0,
        RES_FULL  = 2'd1,
        RES_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic    start;
        status_t res_status;
        logic    res_data;
        logic    batch_init;
        logic    push;
        logic    pop;
        logic    take;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic occ_zero;
        logic occ_one;
        logic full;
        logic more;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/wsd_ctrl.sv
// deque controller: command decode and result sequencing
module wsd_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [wsd_pkg::CMD_W-1:0]  s_command,
    input  wsd_pkg::dp_stat_t          stat,
    output wsd_pkg::dp_cmd_t           cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOAD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.start      = 1'b1;
                    cmd.res_status = wsd_pkg::RES_OK;
                    cmd.res_data   = 1'b1;
                    state_next     = S_LOAD;
                    case (wsd_pkg::command_t'(s_command))
                        wsd_pkg::CMD_PUSH: begin
                            cmd.res_data = 1'b0;
                            if (stat.full) begin
                                cmd.res_status = wsd_pkg::RES_FULL;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                        wsd_pkg::CMD_POP: begin
                            if (stat.occ_zero) begin
                                cmd.res_status = wsd_pkg::RES_EMPTY;
                                cmd.res_data   = 1'b0;
                            end else begin
                                cmd.pop = 1'b1;
                            end
                        end
                        wsd_pkg::CMD_STEAL: begin
                            if (stat.occ_zero) begin
                                cmd.res_status = wsd_pkg::RES_EMPTY;
                                cmd.res_data   = 1'b0;
                            end else begin
                                cmd.take = 1'b1;
                            end
                        end
                        wsd_pkg::CMD_BATCH: begin
                            if (stat.occ_zero || stat.occ_one) begin
                                cmd.res_status = wsd_pkg::RES_EMPTY;
                                cmd.res_data   = 1'b0;
                            end else begin
                                cmd.take       = 1'b1;
                                cmd.batch_init = 1'b1;
                            end
                        end
                        default: begin
                            cmd.res_status = wsd_pkg::RES_EMPTY;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    if (stat.more) begin
                        // next handle of a batch steal
                        cmd.take = 1'b1;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/wsd_datapath.sv
// deque datapath: slot memory, ring indices and result register
module wsd_datapath #(
    parameter int CAPACITY     = wsd_pkg::CAPACITY,
    parameter int HANDLE_WIDTH = wsd_pkg::HANDLE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [wsd_pkg::WORK_W-1:0]    work_in,
    input  wsd_pkg::dp_cmd_t              cmd,
    output wsd_pkg::dp_stat_t             stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wsd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [wsd_pkg::STATUS_W-1:0]  m_tuser,
    output logic                          m_tlast
);

    localparam int IdxW    = $clog2(2 * CAPACITY);
    localparam int IdxW1   = IdxW + 1;
    localparam int AddrW   = $clog2(CAPACITY);
    localparam int RemW    = $clog2(CAPACITY / 2 + 1);
    localparam int ExtW    = HANDLE_WIDTH + wsd_pkg::WORK_W;
    localparam int OccExtW = IdxW + wsd_pkg::OCC_W;
    localparam logic [IdxW-1:0] IdxLast = IdxW'(2 * CAPACITY - 1);
    localparam logic [IdxW-1:0] CapIdx  = IdxW'(CAPACITY);

    function automatic logic [AddrW-1:0] slot_of(input logic [IdxW-1:0] idx);
        logic [IdxW-1:0] s;
        s = (idx >= CapIdx) ? (idx - CapIdx) : idx;
        return s[AddrW-1:0];
    endfunction

    function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
        return (idx == IdxLast) ? '0 : (idx + IdxW'(1));
    endfunction

    function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] idx);
        return (idx == '0) ? IdxLast : (idx - IdxW'(1));
    endfunction

    logic [HANDLE_WIDTH-1:0]     slots_reg [CAPACITY];
    logic [HANDLE_WIDTH-1:0]     rd_data_reg;
    logic [IdxW-1:0]             head_reg, head_next;
    logic [IdxW-1:0]             tail_reg, tail_next;
    logic [RemW-1:0]             remain_reg, remain_next;
    wsd_pkg::status_t            res_status_reg;
    logic                        res_data_reg;
    logic                        out_valid_reg, out_valid_next;
    wsd_pkg::status_t            out_status_reg;
    logic [wsd_pkg::WORK_W-1:0]  out_work_reg;
    logic [wsd_pkg::OCC_W-1:0]   out_occ_reg;
    logic                        out_last_reg;

    logic [IdxW:0]               diff;
    logic [IdxW-1:0]             occ;
    logic [IdxW-1:0]             half_m1;
    logic [IdxW-1:0]             head_m1;
    logic [AddrW-1:0]            rd_addr;
    logic [AddrW-1:0]            wr_addr;
    logic                        rd_en;
    logic [ExtW-1:0]             work_ext;
    logic [ExtW-1:0]             rd_ext;
    logic [OccExtW-1:0]          occ_ext;

    // occupancy is head minus tail modulo twice the capacity
    always_comb begin
        diff = {1'b0, head_reg} - {1'b0, tail_reg};
        if (head_reg < tail_reg) begin
            diff = diff + IdxW1'(2 * CAPACITY);
        end
        occ = diff[IdxW-1:0];
    end

    assign half_m1  = (occ >> 1) - IdxW'(1);
    assign head_m1  = idx_dec(head_reg);
    assign wr_addr  = slot_of(head_reg);
    assign work_ext = {{HANDLE_WIDTH{1'b0}}, work_in};
    assign rd_ext   = {{wsd_pkg::WORK_W{1'b0}}, rd_data_reg};
    assign occ_ext  = {{wsd_pkg::OCC_W{1'b0}}, occ};

    assign stat.occ_zero = (occ == '0);
    assign stat.occ_one  = (occ == IdxW'(1));
    assign stat.full     = (occ == CapIdx);
    assign stat.more     = (remain_reg != '0);
    assign stat.out_free = !out_valid_reg || m_tready;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        rd_en     = 1'b0;
        rd_addr   = slot_of(tail_reg);
        if (cmd.push) begin
            head_next = idx_inc(head_reg);
        end
        if (cmd.pop) begin
            rd_en   = 1'b1;
            rd_addr = slot_of(head_m1);
            // popping the only handle moves the tail instead
            if (stat.occ_one) begin
                tail_next = idx_inc(tail_reg);
            end else begin
                head_next = head_m1;
            end
        end
        if (cmd.take) begin
            rd_en     = 1'b1;
            rd_addr   = slot_of(tail_reg);
            tail_next = idx_inc(tail_reg);
        end
    end

    always_comb begin
        remain_next = remain_reg;
        if (cmd.start) begin
            remain_next = cmd.batch_init ? half_m1[RemW-1:0] : '0;
        end else if (cmd.load_out && stat.more) begin
            remain_next = remain_reg - RemW'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // slot memory with registered read
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            slots_reg[wr_addr] <= work_ext[HANDLE_WIDTH-1:0];
        end
        if (rd_en) begin
            rd_data_reg <= slots_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            res_status_reg <= cmd.res_status;
            res_data_reg   <= cmd.res_data;
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_work_reg   <= res_data_reg ? rd_ext[wsd_pkg::WORK_W-1:0] : '0;
            out_occ_reg    <= occ_ext[wsd_pkg::OCC_W-1:0];
            out_last_reg   <= !stat.more;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{wsd_pkg::PAD_W{1'b0}}, out_occ_reg, out_work_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/work_stealing_deque_top.sv
// work stealing deque: top level joining controller and datapath
// m_tvalid rises when S_LOAD loads the output register; S_LOAD waits while a result is untaken
// new commands are taken only in S_IDLE, after the last result has been loaded for output
// batch steal: one result per cycle after the first while m_tready stays high
// reset: head and tail indices and output valid clear at once, no clearing pass
// slot memory is not cleared, only entries written by a push are ever read
module work_stealing_deque_top #(
    parameter int CAPACITY     = wsd_pkg::CAPACITY,
    parameter int HANDLE_WIDTH = wsd_pkg::HANDLE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wsd_pkg::WORK_W-1:0]    s_tdata,  // work_in
    input  logic [wsd_pkg::CMD_W-1:0]     s_tuser,  // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wsd_pkg::M_TDATA_W-1:0] m_tdata,  // work_out, occupancy, zero pad
    output logic [wsd_pkg::STATUS_W-1:0]  m_tuser,  // status
    output logic                          m_tlast
);

    wsd_pkg::dp_cmd_t  cmd;
    wsd_pkg::dp_stat_t stat;

    wsd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (s_tuser),
        .stat      (stat),
        .cmd       (cmd)
    );

    wsd_datapath #(
        .CAPACITY     (CAPACITY),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .work_in  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/wsd_checker.sv
// port checker for the work stealing deque and its bind
`include "assert_macros.svh"

module wsd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wsd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [wsd_pkg::STATUS_W-1:0]  m_tuser,
    input logic                          m_tlast
);

    `WSD_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    `WSD_ASSERT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled transfer changed")

    `WSD_ASSERT(a_refused_single, aclk, aresetn, m_tvalid && (m_tuser != wsd_pkg::RES_OK) |-> m_tlast && (m_tdata[wsd_pkg::WORK_W-1:0] == '0), "refused result not single or work nonzero")

    `WSD_ASSERT(a_empty_occ, aclk, aresetn, m_tvalid && (m_tuser == wsd_pkg::RES_EMPTY) |-> (m_tdata[wsd_pkg::WORK_W +: wsd_pkg::OCC_W] == '0) || (m_tdata[wsd_pkg::WORK_W +: wsd_pkg::OCC_W] == wsd_pkg::OCC_W'(1)), "empty result with occupancy above one")

endmodule

bind work_stealing_deque_top wsd_checker u_wsd_checker (.*);

// File: dv/wsd_checker.sv
// checker for the work stealing deque: predicts results from input transfers and compares them
`timescale 1ns / 1ps

module wsd_scoreboard (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [wsd_pkg::WORK_W-1:0]          s_tdata,  // work_in
    input  logic [wsd_pkg::CMD_W-1:0]           s_tuser,  // command
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [wsd_pkg::M_TDATA_W-1:0]       m_tdata,  // work_out, occupancy, zero pad
    input  logic [wsd_pkg::STATUS_W-1:0]        m_tuser,  // status
    input  logic                                m_tlast,
    output int                                  errors = 0,
    output int                                  pending = 0
);

    localparam int INDEX_SPAN = 2 * wsd_pkg::CAPACITY;

    typedef struct packed {
        wsd_pkg::status_t              status;
        logic [wsd_pkg::WORK_W-1:0]    work;
        logic [wsd_pkg::OCC_W-1:0]     occ;
        logic                          last;
    } deque_result_t;

    deque_result_t              expected_results[$];
    logic [wsd_pkg::WORK_W-1:0] handles[wsd_pkg::CAPACITY];
    int                         head_cnt = 0;
    int                         tail_cnt = 0;

    function automatic int held_count();
        return (head_cnt + INDEX_SPAN - tail_cnt) % INDEX_SPAN;
    endfunction

    function automatic void expect_result(wsd_pkg::status_t status,
                                          logic [wsd_pkg::WORK_W-1:0] work,
                                          logic last);
        deque_result_t r;
        r.status = status;
        r.work   = work;
        r.occ    = wsd_pkg::OCC_W'(held_count());
        r.last   = last;
        expected_results = {expected_results, r};
    endfunction

    function automatic logic [wsd_pkg::WORK_W-1:0] take_from_tail();
        logic [wsd_pkg::WORK_W-1:0] w;
        w        = handles[tail_cnt % wsd_pkg::CAPACITY];
        tail_cnt = (tail_cnt + 1) % INDEX_SPAN;
        return w;
    endfunction

    function automatic void predict_command(wsd_pkg::command_t cmd,
                                            logic [wsd_pkg::WORK_W-1:0] work_in);
        int                         count;
        logic [wsd_pkg::WORK_W-1:0] w;
        if (cmd == wsd_pkg::CMD_PUSH) begin
            if (held_count() >= wsd_pkg::CAPACITY) begin
                expect_result(wsd_pkg::RES_FULL, '0, 1'b1);
            end else begin
                handles[head_cnt % wsd_pkg::CAPACITY] = work_in;
                head_cnt = (head_cnt + 1) % INDEX_SPAN;
                expect_result(wsd_pkg::RES_OK, '0, 1'b1);
            end
        end else if (held_count() == 0) begin
            expect_result(wsd_pkg::RES_EMPTY, '0, 1'b1);
        end else if (cmd == wsd_pkg::CMD_POP) begin
            head_cnt = (head_cnt + INDEX_SPAN - 1) % INDEX_SPAN;
            w = handles[head_cnt % wsd_pkg::CAPACITY];
            // only handle taken: tail steps onto the restored head
            if (head_cnt == tail_cnt) begin
                tail_cnt = (tail_cnt + 1) % INDEX_SPAN;
                head_cnt = (head_cnt + 1) % INDEX_SPAN;
            end
            expect_result(wsd_pkg::RES_OK, w, 1'b1);
        end else if (cmd == wsd_pkg::CMD_STEAL) begin
            w = take_from_tail();
            expect_result(wsd_pkg::RES_OK, w, 1'b1);
        end else begin
            count = held_count() / 2;
            if (count == 0) begin
                expect_result(wsd_pkg::RES_EMPTY, '0, 1'b1);
            end else begin
                for (int k = 0; k < count; k++) begin
                    w = take_from_tail();
                    expect_result(wsd_pkg::RES_OK, w, k + 1 == count);
                end
            end
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("wsd_scoreboard: %s mismatch, got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task automatic check_result();
        deque_result_t got;
        deque_result_t want;
        got.status = wsd_pkg::status_t'(m_tuser);
        got.work   = m_tdata[wsd_pkg::WORK_W-1:0];
        got.occ    = m_tdata[wsd_pkg::WORK_W +: wsd_pkg::OCC_W];
        got.last   = m_tlast;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected transfer", got.work, 0);
        end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.work !== want.work)
                report_mismatch("work_out", got.work, want.work);
            if (got.occ !== want.occ)
                report_mismatch("occupancy", got.occ, want.occ);
            if (got.last !== want.last)
                report_mismatch("last", got.last, want.last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            head_cnt = 0;
            tail_cnt = 0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_command(wsd_pkg::command_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                check_result();
        end
        pending = expected_results.size();
    end

endmodule

// File: dv/tb.sv
// testbench top for the work stealing deque: stimulus, reset, clock and verdict
`timescale 1ns / 1ps

module tb;

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [wsd_pkg::WORK_W-1:0]        s_tdata  = '0;  // work_in
    logic [wsd_pkg::CMD_W-1:0]         s_tuser  = wsd_pkg::CMD_PUSH;  // command
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [wsd_pkg::M_TDATA_W-1:0]     m_tdata;  // work_out, occupancy, zero pad
    logic [wsd_pkg::STATUS_W-1:0]      m_tuser;  // status
    logic                              m_tlast;
    logic                              stall_on = 1'b1;
    int                                errors;
    int                                pending;

    always #10 aclk = ~aclk;

    work_stealing_deque_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    wsd_scoreboard u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    always @(posedge aclk) begin
        m_tready <= stall_on ? ($urandom_range(99) >= 27) : 1'b1;
    end

    task automatic send_command(wsd_pkg::command_t cmd, logic [wsd_pkg::WORK_W-1:0] work);
        while (stall_on && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= work;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random(bit filling);
        int                         pick;
        wsd_pkg::command_t          cmd;
        logic [wsd_pkg::WORK_W-1:0] work;
        pick = $urandom_range(99);
        if (filling)
            cmd = (pick < 70) ? wsd_pkg::CMD_PUSH : (pick < 80) ? wsd_pkg::CMD_POP :
                  (pick < 90) ? wsd_pkg::CMD_STEAL : wsd_pkg::CMD_BATCH;
        else
            cmd = (pick < 25) ? wsd_pkg::CMD_PUSH : (pick < 50) ? wsd_pkg::CMD_POP :
                  (pick < 75) ? wsd_pkg::CMD_STEAL : wsd_pkg::CMD_BATCH;
        case ($urandom_range(9))
            0:       work = '0;
            1:       work = '1;
            default: work = $urandom;
        endcase
        send_command(cmd, work);
    endtask

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int burst;
        bit filling;
        burst   = 0;
        filling = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty deque on every taking command
        send_command(wsd_pkg::CMD_POP, 32'h1234_5678);
        send_command(wsd_pkg::CMD_STEAL, '1);
        send_command(wsd_pkg::CMD_BATCH, '0);
        // batch with one handle, then pop of the only handle
        send_command(wsd_pkg::CMD_PUSH, '0);
        send_command(wsd_pkg::CMD_BATCH, '1);
        send_command(wsd_pkg::CMD_POP, '0);
        // fill to capacity, refuse one more, then drain half and steal one
        for (int i = 0; i < wsd_pkg::CAPACITY; i++)
            send_command(wsd_pkg::CMD_PUSH, (i == 0) ? '1 :
                         (i[0] ? 32'h5555_5555 : 32'hAAAA_AAAA) ^ wsd_pkg::WORK_W'(i));
        send_command(wsd_pkg::CMD_PUSH, 32'hDEAD_BEEF);
        send_command(wsd_pkg::CMD_BATCH, '0);
        send_command(wsd_pkg::CMD_STEAL, '0);

        for (int n = 0; n < 470; n++) begin
            stall_on <= !(n >= 150 && n < 300);
            if (burst == 0) begin
                filling = !filling;
                burst   = $urandom_range(40, 10);
            end
            burst--;
            send_random(filling);
        end
        s_tvalid <= 1'b0;

        do @(negedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/wsd_pkg.sv
rtl/wsd_ctrl.sv
rtl/wsd_datapath.sv
rtl/work_stealing_deque_top.sv
rtl/wsd_checker.sv
dv/wsd_checker.sv
dv/tb.sv
